// File: hw/rtl/pee_pkg.sv
`default_nettype none

package pee_pkg;

   localparam int STACK_DEPTH = 16;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   localparam logic [2:0] KIND_OPEN   = 3'd0;
   localparam logic [2:0] KIND_CLOSE  = 3'd1;
   localparam logic [2:0] KIND_PLUS   = 3'd2;
   localparam logic [2:0] KIND_TIMES  = 3'd3;
   localparam logic [2:0] KIND_NUMBER = 3'd4;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_MALFORMED = 2'd1;
   localparam logic [1:0] ST_OVERFLOW  = 2'd2;

   typedef struct packed {
      logic [2:0]         token_kind;
      logic signed [31:0] token_value;
      logic               last_token;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_value;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      logic        op_valid;
      logic        op_times;
      logic        acc_valid;
      logic [31:0] acc;
   } frame_type;

   localparam int FRAME_W = $bits(frame_type);

endpackage

`default_nettype wire

// File: hw/rtl/pee_ram.sv
`default_nettype none

module pee_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                             clock,
   input  wire logic                             wr_en,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                 wr_data,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// File: hw/rtl/pee_fold.sv
`default_nettype none

module pee_fold
   import pee_pkg::*;
(
   input  wire frame_type   frame_in,
   input  wire logic [31:0] operand,
   output frame_type        frame_out,
   output logic             bad
);

   logic [31:0] prod;
   logic [31:0] sum;

   assign prod = frame_in.acc * operand;
   assign sum  = frame_in.acc + operand;
   assign bad  = !frame_in.op_valid;

   always_comb begin
      frame_out           = frame_in;
      frame_out.acc_valid = 1'b1;
      if (!frame_in.acc_valid) begin
         frame_out.acc = operand;
      end else if (frame_in.op_times) begin
         frame_out.acc = prod;
      end else begin
         frame_out.acc = sum;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/prefix_expression_evaluator.sv
// channel | direction | ports                            | moves
// req     | in        | req_valid, req_stall, req_data   | one token per request
// rsp     | out       | rsp_valid, rsp_stall, rsp_data   | value and status per expression
//
// One token per cycle while req_stall is low; a result appears the cycle after the last token is taken.
// Top and parent frames sit in registers; deeper frames live in a RAM whose
// registered read always prefetches the frame below the parent.
// Synchronous reset clears the stack depth, top-level value and sticky status.
// req_stall rises only while a result is held and rsp_stall is high.
`default_nettype none

module prefix_expression_evaluator
   import pee_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   logic [CNT_W-1:0] count_ff, count_in;
   frame_type        top_ff, top_in;
   frame_type        par_ff, par_in;
   logic [31:0]      top_value_ff, top_value_in;
   logic             top_valid_ff, top_valid_in;
   logic [1:0]       err_ff, err_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   logic             fwd_sel_ff;
   frame_type        fwd_data_ff;

   logic             req_fire;
   logic             is_close;
   frame_type        fold_src;
   logic [31:0]      fold_opnd;
   frame_type        fold_out;
   logic             fold_bad;
   frame_type        par_fetch;
   logic [FRAME_W-1:0] ram_rd;
   logic             wr_en;
   logic [CNT_W-1:0] wr_cnt;
   logic [CNT_W-1:0] rd_cnt;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic [1:0]       status;

   assign req_fire  = req_valid && !req_stall;
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign is_close  = (req_data.token_kind == KIND_CLOSE);
   assign fold_src  = is_close ? par_ff : top_ff;
   assign fold_opnd = is_close ? top_ff.acc : req_data.token_value;

   pee_fold u_fold (
      .frame_in  (fold_src),
      .operand   (fold_opnd),
      .frame_out (fold_out),
      .bad       (fold_bad)
   );

   assign wr_cnt  = count_ff - CNT_W'(2);
   assign rd_cnt  = count_in - CNT_W'(3);
   assign wr_addr = wr_cnt[ADDR_W-1:0];
   assign rd_addr = rd_cnt[ADDR_W-1:0];

   pee_ram #(
      .WIDTH (FRAME_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (par_ff),
      .rd_addr (rd_addr),
      .rd_data (ram_rd)
   );

   assign par_fetch = fwd_sel_ff ? fwd_data_ff : frame_type'(ram_rd);

   always_comb begin
      count_in     = count_ff;
      top_in       = top_ff;
      par_in       = par_ff;
      top_value_in = top_value_ff;
      top_valid_in = top_valid_ff;
      err_in       = err_ff;
      wr_en        = 1'b0;
      status       = ST_OK;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (req_fire) begin
         if (err_ff == ST_OK) begin
            case (req_data.token_kind)
               KIND_OPEN: begin
                  if ((count_ff == '0 && top_valid_ff) ||
                      (count_ff != '0 && !top_ff.op_valid)) begin
                     err_in = ST_MALFORMED;
                  end else if (count_ff >= CNT_W'(STACK_DEPTH)) begin
                     err_in = ST_OVERFLOW;
                  end else begin
                     wr_en    = (count_ff >= CNT_W'(2));
                     par_in   = top_ff;
                     top_in   = '0;
                     count_in = count_ff + CNT_W'(1);
                  end
               end
               KIND_PLUS, KIND_TIMES: begin
                  if (count_ff == '0 || top_ff.op_valid) begin
                     err_in = ST_MALFORMED;
                  end else begin
                     top_in.op_valid = 1'b1;
                     top_in.op_times = (req_data.token_kind == KIND_TIMES);
                  end
               end
               KIND_NUMBER: begin
                  if (count_ff == '0) begin
                     if (top_valid_ff) begin
                        err_in = ST_MALFORMED;
                     end else begin
                        top_value_in = req_data.token_value;
                        top_valid_in = 1'b1;
                     end
                  end else if (fold_bad) begin
                     err_in = ST_MALFORMED;
                  end else begin
                     top_in = fold_out;
                  end
               end
               KIND_CLOSE: begin
                  if (count_ff == '0 || !top_ff.op_valid || !top_ff.acc_valid) begin
                     err_in = ST_MALFORMED;
                  end else begin
                     count_in = count_ff - CNT_W'(1);
                     if (count_ff == CNT_W'(1)) begin
                        if (top_valid_ff) begin
                           err_in = ST_MALFORMED;
                        end else begin
                           top_value_in = top_ff.acc;
                           top_valid_in = 1'b1;
                        end
                     end else if (fold_bad) begin
                        err_in = ST_MALFORMED;
                     end else begin
                        top_in = fold_out;
                        par_in = par_fetch;
                     end
                  end
               end
               default: begin
                  err_in = ST_MALFORMED;
               end
            endcase
         end

         if (req_data.last_token) begin
            if (err_in == ST_OK && (count_in != '0 || !top_valid_in)) begin
               status = ST_MALFORMED;
            end else begin
               status = err_in;
            end
            rsp_in.status       = status;
            rsp_in.result_value = (status == ST_OK) ? top_value_in : '0;
            rsp_valid_in        = 1'b1;
            count_in            = '0;
            top_value_in        = '0;
            top_valid_in        = 1'b0;
            err_in              = ST_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         top_value_ff <= '0;
         top_valid_ff <= 1'b0;
         err_ff       <= ST_OK;
         rsp_valid_ff <= 1'b0;
         fwd_sel_ff   <= 1'b0;
      end else begin
         count_ff     <= count_in;
         top_value_ff <= top_value_in;
         top_valid_ff <= top_valid_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
         fwd_sel_ff   <= wr_en && (wr_addr == rd_addr);
      end
      top_ff      <= top_in;
      par_ff      <= par_in;
      rsp_ff      <= rsp_in;
      fwd_data_ff <= par_ff;
   end

endmodule

`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
   import pee_pkg::*;

   localparam int LONG_HOLD    = 300;
   localparam int QUIET_LIMIT  = 2000;
   localparam int PHASE_TOKENS = 215;
   localparam int DRAIN_CYCLES = 20;

   class eval_scoreboard;
      frame_type   frames [STACK_DEPTH];
      int          depth;
      logic [31:0] top_value;
      bit          top_valid;
      logic [1:0]  status_code;
      rsp_type     pending_results [$];
      int          errors;

      function void clear_expr();
         depth       = 0;
         top_value   = '0;
         top_valid   = 1'b0;
         status_code = ST_OK;
      endfunction

      function void flag(logic [1:0] code);
         if (status_code == ST_OK) begin
            status_code = code;
         end
      endfunction

      function void fold_operand(logic [31:0] v);
         if (depth == 0) begin
            if (top_valid) begin
               flag(ST_MALFORMED);
            end else begin
               top_value = v;
               top_valid = 1'b1;
            end
         end else if (!frames[depth - 1].op_valid) begin
            flag(ST_MALFORMED);
         end else if (!frames[depth - 1].acc_valid) begin
            frames[depth - 1].acc       = v;
            frames[depth - 1].acc_valid = 1'b1;
         end else if (frames[depth - 1].op_times) begin
            frames[depth - 1].acc = frames[depth - 1].acc * v;
         end else begin
            frames[depth - 1].acc = frames[depth - 1].acc + v;
         end
      endfunction

      function void apply_token(logic [2:0] kind, logic [31:0] value);
         logic [31:0] group_value;
         case (kind)
            KIND_OPEN: begin
               if ((depth == 0 && top_valid) || (depth > 0 && !frames[depth - 1].op_valid)) begin
                  flag(ST_MALFORMED);
               end else if (depth >= STACK_DEPTH) begin
                  flag(ST_OVERFLOW);
               end else begin
                  frames[depth] = '0;
                  depth++;
               end
            end
            KIND_PLUS, KIND_TIMES: begin
               if (depth == 0 || frames[depth - 1].op_valid) begin
                  flag(ST_MALFORMED);
               end else begin
                  frames[depth - 1].op_valid = 1'b1;
                  frames[depth - 1].op_times = (kind == KIND_TIMES);
               end
            end
            KIND_NUMBER: begin
               fold_operand(value);
            end
            KIND_CLOSE: begin
               if (depth == 0 || !frames[depth - 1].op_valid || !frames[depth - 1].acc_valid) begin
                  flag(ST_MALFORMED);
               end else begin
                  group_value = frames[depth - 1].acc;
                  depth--;
                  fold_operand(group_value);
               end
            end
            default: begin
               flag(ST_MALFORMED);
            end
         endcase
      endfunction

      function void note_token(req_type t);
         rsp_type r;
         if (status_code == ST_OK) begin
            apply_token(t.token_kind, t.token_value);
         end
         if (t.last_token) begin
            if (status_code == ST_OK && (depth != 0 || !top_valid)) begin
               flag(ST_MALFORMED);
            end
            r.result_value = (status_code == ST_OK) ? top_value : '0;
            r.status       = status_code;
            pending_results.insert(pending_results.size(), r);
            clear_expr();
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (pending_results.size() == 0) begin
            $error("unexpected result: result_value %0d status %0d",
                   got.result_value, got.status);
            errors++;
            return;
         end
         want = pending_results.pop_front();
         if (got.result_value !== want.result_value) begin
            $error("result_value: expected %0d, got %0d", want.result_value, got.result_value);
            errors++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
         end
      endfunction

      function int pending();
         return pending_results.size();
      endfunction
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   eval_scoreboard sb = new;
   req_type        tokens [$];
   int             send_idle_pct  = 0;
   int             recv_stall_pct = 0;
   int             hold_asks      = 0;
   int             hold_seen      = 0;
   int             hold_left      = 0;
   int             quiet_cycles   = 0;
   int             sent           = 0;

   prefix_expression_evaluator i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      if (hold_asks != hold_seen) begin
         hold_seen = hold_asks;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_result(rsp_data);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   function automatic void tok(logic [2:0] kind, logic [31:0] value);
      req_type t;
      t.token_kind  = kind;
      t.token_value = value;
      t.last_token  = 1'b0;
      tokens.insert(tokens.size(), t);
   endfunction

   function automatic logic [31:0] rand_value();
      case ($urandom_range(3))
         0: return $urandom_range(10) - 5;
         1: begin
            case ($urandom_range(4))
               0: return 32'h8000_0000;
               1: return 32'h7fff_ffff;
               2: return 32'hffff_ffff;
               3: return 32'h0000_0001;
               default: return 32'h0;
            endcase
         end
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [2:0] rand_op();
      return $urandom_range(1) ? KIND_TIMES : KIND_PLUS;
   endfunction

   function automatic void emit_group(int levels);
      int n;
      tok(KIND_OPEN, $urandom());
      tok(rand_op(), $urandom());
      n = $urandom_range(4, 1);
      for (int i = 0; i < n; i++) begin
         if (levels > 0 && $urandom_range(2) == 0) begin
            emit_group(levels - 1);
         end else begin
            tok(KIND_NUMBER, rand_value());
         end
      end
      tok(KIND_CLOSE, $urandom());
   endfunction

   function automatic void emit_chain(int levels);
      for (int i = 0; i < levels; i++) begin
         tok(KIND_OPEN, $urandom());
         tok(rand_op(), $urandom());
      end
      tok(KIND_NUMBER, rand_value());
      for (int i = 0; i < levels; i++) begin
         if ($urandom_range(1)) begin
            tok(KIND_NUMBER, rand_value());
         end
         tok(KIND_CLOSE, $urandom());
      end
   endfunction

   // mostly well-formed expressions, some broken or pure noise
   function automatic void gen_expr();
      int      pick;
      int      idx;
      int      n;
      req_type extra;
      pick = $urandom_range(99);
      if (pick < 8) begin
         tok(KIND_NUMBER, rand_value());
      end else if (pick < 11) begin
         emit_chain(STACK_DEPTH);
      end else if (pick < 13) begin
         emit_chain(STACK_DEPTH + 1);
      end else if (pick < 20) begin
         n = $urandom_range(6, 1);
         for (int i = 0; i < n; i++) begin
            tok(3'($urandom_range(7)), $urandom());
         end
      end else begin
         emit_group($urandom_range(3));
      end
      if (pick >= 78) begin
         idx = $urandom_range(tokens.size() - 1);
         case ($urandom_range(2))
            0: tokens[idx].token_kind = 3'($urandom_range(7));
            1: tokens = tokens[0:idx];
            default: begin
               extra.token_kind  = 3'($urandom_range(7));
               extra.token_value = $urandom();
               extra.last_token  = 1'b0;
               tokens.insert(idx, extra);
            end
         endcase
      end
   endfunction

   task automatic send_token(req_type t);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      sb.note_token(t);
      @(negedge clock);
   endtask

   task automatic send_expr();
      tokens[tokens.size() - 1].last_token = 1'b1;
      foreach (tokens[i]) begin
         send_token(tokens[i]);
      end
      sent += tokens.size();
      tokens.delete();
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do begin
         @(negedge clock);
      end while (sb.pending() != 0);
   endtask

   initial begin
      bit held;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed
      tok(KIND_NUMBER, 32'h7fff_ffff);
      send_expr();
      tok(KIND_OPEN, $urandom());
      tok(KIND_PLUS, $urandom());
      tok(KIND_NUMBER, 32'h7fff_ffff);
      tok(KIND_NUMBER, 32'h1);
      tok(KIND_CLOSE, $urandom());
      send_expr();
      tok(KIND_OPEN, 32'hffff_ffff);
      tok(KIND_TIMES, 32'hffff_ffff);
      tok(KIND_NUMBER, 32'h8000_0000);
      tok(KIND_NUMBER, 32'hffff_ffff);
      tok(KIND_OPEN, 32'hffff_ffff);
      tok(KIND_PLUS, 32'hffff_ffff);
      tok(KIND_NUMBER, 32'h3);
      tok(KIND_CLOSE, 32'hffff_ffff);
      tok(KIND_CLOSE, 32'hffff_ffff);
      send_expr();
      tok(3'd7, 32'hffff_ffff);
      send_expr();
      tok(3'd5, $urandom());
      tok(KIND_NUMBER, 32'h5);
      send_expr();
      tok(KIND_OPEN, $urandom());
      tok(KIND_PLUS, $urandom());
      tok(KIND_CLOSE, $urandom());
      send_expr();
      tok(KIND_NUMBER, 32'h1);
      tok(KIND_NUMBER, 32'h2);
      send_expr();
      tok(KIND_OPEN, $urandom());
      tok(KIND_NUMBER, 32'h5);
      tok(KIND_CLOSE, $urandom());
      send_expr();
      tok(KIND_OPEN, $urandom());
      tok(KIND_OPEN, $urandom());
      send_expr();
      tok(KIND_OPEN, $urandom());
      tok(KIND_TIMES, $urandom());
      tok(KIND_NUMBER, 32'h2);
      send_expr();
      wait_drained();

      held = 1'b0;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
            default: begin send_idle_pct = 16; recv_stall_pct = 16; end
         endcase
         sent = 0;
         while (sent < PHASE_TOKENS) begin
            if (!held && phase == 0 && sent >= PHASE_TOKENS / 3) begin
               held = 1'b1;
               hold_asks++;
            end
            gen_expr();
            send_expr();
         end
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (sb.errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
